FILE: hw/rtl/crcbe_pkg.sv
package crcbe_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned HALF_W   = 16;
    localparam int unsigned APB_W    = 32;
    localparam int unsigned ADDR_W   = 3;

    localparam logic        REG_IDX_MODE = 1'b0;
    localparam logic        REG_IDX_POLY = 1'b1;

    localparam logic        MODE_CRC16 = 1'b0;
    localparam logic        MODE_CRC32 = 1'b1;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;

    typedef struct packed {
        logic             width_mode;
        logic [CRC_W-1:0] polynomial;
    } t_cfg;

endpackage

FILE: hw/rtl/crcbe_in_if.sv
interface crcbe_in_if;

    logic                             valid;
    logic                             ready;
    logic [crcbe_pkg::DATA_W-1:0]     data_byte;
    logic                             last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

FILE: hw/rtl/crcbe_out_if.sv
interface crcbe_out_if;

    logic                             valid;
    logic                             ready;
    logic [crcbe_pkg::CRC_W-1:0]      crc_value;
    logic                             is_final;

    modport source (output valid, output crc_value, output is_final, input ready);
    modport sink   (input valid, input crc_value, input is_final, output ready);

endinterface

FILE: hw/rtl/crc16_crc32_bytewise_engine.sv
// Byte-wise CRC-16/CRC-32 engine (MSB first, non-reflected, zero init, no final XOR).
// Takes one byte per cycle on i_byte_if while the output is not stalled, and returns
// one word per byte on o_crc_if via the input and result registers. The byte is captured
// in an input register; the eight-bit fold into the running CRC is done in logic
// between that register and the result register, and the accumulator is updated in
// the same cycle, so consecutive bytes of a message flow without gaps. A result
// held by a stalled sink blocks a full input register, which then takes no new
// byte. After a byte flagged as last, the accumulator returns to zero for the next message.
// Registers (APB, 32-bit words): 0x0 width_mode (0 = CRC-16, 1 = CRC-32, reset 1),
// 0x4 polynomial without its top bit (reset 0x04C11DB7; low 16 bits in CRC-16 mode).
// Change registers only while the engine is idle.
module crc16_crc32_bytewise_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    crcbe_in_if.sink                        i_byte_if,
    crcbe_out_if.source                     o_crc_if,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crcbe_pkg::ADDR_W-1:0]    paddr,
    input  logic [crcbe_pkg::APB_W-1:0]     pwdata,
    output logic [crcbe_pkg::APB_W-1:0]     prdata,
    output logic                            pready
);

    crcbe_pkg::t_cfg                    w_cfg;
    logic                               r_s1_valid;
    logic [crcbe_pkg::DATA_W-1:0]       r_s1_byte;
    logic                               r_s1_last;
    logic [crcbe_pkg::CRC_W-1:0]        r_acc;
    logic [crcbe_pkg::CRC_W-1:0]        n_crc;
    logic                               r_out_valid;
    logic [crcbe_pkg::CRC_W-1:0]        r_out_crc;
    logic                               r_out_final;
    logic                               w_s1_adv;
    logic                               w_in_acc;

    crcbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    crcbe_fold u_fold (
        .i_cfg  (w_cfg),
        .i_acc  (r_acc),
        .i_data (r_s1_byte),
        .o_crc  (n_crc)
    );

    assign w_s1_adv        = r_s1_valid && (!r_out_valid || o_crc_if.ready);
    assign i_byte_if.ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc        = i_byte_if.valid && i_byte_if.ready;

    // capture byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte_if.ready) begin
            r_s1_valid <= i_byte_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_byte <= i_byte_if.data_byte;
            r_s1_last <= i_byte_if.last_byte;
        end
    end

    // advance accumulator; drop to zero after last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_s1_adv) begin
            r_acc <= r_s1_last ? '0 : n_crc;
        end
    end

    // hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_crc_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_crc   <= n_crc;
            r_out_final <= r_s1_last;
        end
    end

    assign o_crc_if.valid     = r_out_valid;
    assign o_crc_if.crc_value = r_out_crc;
    assign o_crc_if.is_final  = r_out_final;

endmodule

FILE: hw/rtl/crcbe_regs.sv
module crcbe_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crcbe_pkg::ADDR_W-1:0]    paddr,
    input  logic [crcbe_pkg::APB_W-1:0]     pwdata,
    output logic [crcbe_pkg::APB_W-1:0]     prdata,
    output logic                            pready,
    output crcbe_pkg::t_cfg                 o_cfg
);

    logic                           w_wr;
    logic                           w_idx;
    logic                           r_width_mode;
    logic [crcbe_pkg::CRC_W-1:0]    r_polynomial;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[crcbe_pkg::ADDR_W-1];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode <= crcbe_pkg::MODE_CRC32;
            r_polynomial <= crcbe_pkg::POLY_RESET;
        end else if (w_wr) begin
            case (w_idx)
                crcbe_pkg::REG_IDX_MODE: r_width_mode <= pwdata[0];
                crcbe_pkg::REG_IDX_POLY: r_polynomial <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            crcbe_pkg::REG_IDX_MODE: prdata = {{(crcbe_pkg::APB_W-1){1'b0}}, r_width_mode};
            crcbe_pkg::REG_IDX_POLY: prdata = r_polynomial;
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.width_mode = r_width_mode;
    assign o_cfg.polynomial = r_polynomial;

endmodule

FILE: hw/rtl/crcbe_fold.sv
module crcbe_fold (
    input  crcbe_pkg::t_cfg                 i_cfg,
    input  logic [crcbe_pkg::CRC_W-1:0]     i_acc,
    input  logic [crcbe_pkg::DATA_W-1:0]    i_data,
    output logic [crcbe_pkg::CRC_W-1:0]     o_crc
);

    logic [crcbe_pkg::CRC_W-1:0]    w_a32;
    logic [crcbe_pkg::HALF_W-1:0]   w_a16;
    logic [crcbe_pkg::HALF_W-1:0]   w_p16;

    always_comb begin
        w_a32 = i_acc ^ {i_data, {(crcbe_pkg::CRC_W-crcbe_pkg::DATA_W){1'b0}}};
        w_a16 = i_acc[crcbe_pkg::HALF_W-1:0]
              ^ {i_data, {(crcbe_pkg::HALF_W-crcbe_pkg::DATA_W){1'b0}}};
        w_p16 = i_cfg.polynomial[crcbe_pkg::HALF_W-1:0];
        for (int k = 0; k < crcbe_pkg::DATA_W; k++) begin
            if (w_a32[crcbe_pkg::CRC_W-1]) begin
                w_a32 = {w_a32[crcbe_pkg::CRC_W-2:0], 1'b0} ^ i_cfg.polynomial;
            end else begin
                w_a32 = {w_a32[crcbe_pkg::CRC_W-2:0], 1'b0};
            end
            if (w_a16[crcbe_pkg::HALF_W-1]) begin
                w_a16 = {w_a16[crcbe_pkg::HALF_W-2:0], 1'b0} ^ w_p16;
            end else begin
                w_a16 = {w_a16[crcbe_pkg::HALF_W-2:0], 1'b0};
            end
        end
        if (i_cfg.width_mode == crcbe_pkg::MODE_CRC32) begin
            o_crc = w_a32;
        end else begin
            o_crc = {{(crcbe_pkg::CRC_W-crcbe_pkg::HALF_W){1'b0}}, w_a16};
        end
    end

endmodule
